### sv/hcm_pkg.sv
package hcm_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // counter, coordinate and accumulator widths
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int HALF_W = (MAX_DIM > 2) ? $clog2((MAX_DIM + 1) / 2) : 1;
    localparam int CNT_W  = $clog2(((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2) + 1);
    localparam int SUM_W  = HALF_W + CNT_W;
    localparam int STEP_W = (HALF_W > 1) ? $clog2(HALF_W) : 1;

    // result field widths
    localparam int CENTER_W = 11;
    localparam int MCOUNT_W = 21;

    // pixel divider: 17-bit numerator, 9-bit divisor, 8-bit quotient
    localparam int PIX_NUM_W = 17;
    localparam int PIX_DEN_W = 9;
    localparam int PIX_Q_W   = 8;

    // hsv conversion constants
    localparam logic [7:0] HUE_BASE_R = 8'd0;
    localparam logic [7:0] HUE_BASE_G = 8'd60;
    localparam logic [7:0] HUE_BASE_B = 8'd120;
    localparam int         HUE_SCALE  = 60;
    localparam int         SAT_SCALE  = 510;
    localparam int         HUE_SHIFT  = 30;
    localparam int         HUE_WRAP   = 180;

    // configuration register map
    localparam int         PADDR_W      = 5;
    localparam int         PDATA_W      = 32;
    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    localparam logic [7:0] RST_HUE_LOW  = 8'd35;
    localparam logic [7:0] RST_HUE_HIGH = 8'd85;
    localparam logic [7:0] RST_SAT_LOW  = 8'd100;
    localparam logic [7:0] RST_SAT_HIGH = 8'd255;
    localparam logic [7:0] RST_VAL_LOW  = 8'd100;
    localparam logic [7:0] RST_VAL_HIGH = 8'd255;

    // frame queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] val_low;
        logic [7:0] val_high;
    } hsv_bounds_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } frame_sum_t;

    typedef struct packed {
        logic              kept;
        logic              v_zero;
        logic              d_zero;
        logic [7:0]        v;
        logic [7:0]        h_base;
        logic [HALF_W-1:0] hx;
        logic [HALF_W-1:0] hy;
        logic              fe;
    } pix_side_t;

endpackage

### sv/hcm_pix_div.sv
module hcm_pix_div
    import hcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [PIX_NUM_W-1:0] num,
    input  logic [PIX_DEN_W-1:0] den,
    output logic [PIX_Q_W-1:0]   quot
);

    // one quotient bit per stage, msb first
    logic [PIX_NUM_W-1:0] rem_reg [PIX_Q_W];
    logic [PIX_DEN_W-1:0] den_reg [PIX_Q_W];
    logic [PIX_Q_W-1:0]   q_reg   [PIX_Q_W];

    for (genvar k = 0; k < PIX_Q_W; k++) begin : g_step
        logic [PIX_NUM_W-1:0] rem_in;
        logic [PIX_DEN_W-1:0] den_in;
        logic [PIX_Q_W-1:0]   q_in;
        logic [PIX_NUM_W-1:0] trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // compare against shifted divisor and subtract
        assign trial = PIX_NUM_W'(den_in) << (PIX_Q_W - 1 - k);
        assign ge    = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (rem_in - trial) : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (PIX_Q_W'(ge) << (PIX_Q_W - 1 - k));
            end
        end
    end

    assign quot = q_reg[PIX_Q_W-1];

endmodule

### sv/hcm_hsv_front.sv
module hcm_hsv_front
    import hcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] pixel_bgr,
    input  logic        line_end,
    input  logic        frame_end,
    input  hsv_bounds_t bounds,
    output logic        fifo_push,
    input  logic        fifo_full,
    output frame_sum_t  fifo_data
);

    logic adv;
    logic accept;

    // raster position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             kept_now;

    // stage 0: captured pixel
    logic              s0_valid_reg;
    logic              s0_kept_reg;
    logic [23:0]       s0_bgr_reg;
    logic [HALF_W-1:0] s0_hx_reg;
    logic [HALF_W-1:0] s0_hy_reg;
    logic              s0_fe_reg;

    // stage 1: max/min and divider operands
    logic [7:0]           r, g, b, v, mn, diff;
    logic                 r_max, g_max;
    logic [8:0]           dpd;
    logic [7:0]           h_base;
    logic                 s1_valid_reg;
    pix_side_t            s1_side_reg;
    logic [PIX_NUM_W-1:0] s1_snum_reg, s1_hnum_reg;
    logic [PIX_DEN_W-1:0] s1_sden_reg, s1_hden_reg;

    // divider pipeline and sideband
    logic [PIX_Q_W-1:0] sq, hq;
    logic [PIX_Q_W-1:0] pv_reg;
    pix_side_t          side_reg [PIX_Q_W];
    pix_side_t          side_out;

    // hsv finish and range test
    logic [8:0] h9;
    logic [7:0] h, s;
    logic       hit;

    // accumulate stage
    logic              a_valid_reg;
    logic              a_hit_reg;
    logic [HALF_W-1:0] a_hx_reg;
    logic [HALF_W-1:0] a_hy_reg;
    logic              a_fe_reg;
    logic [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_x_add, sum_y_add;
    logic [CNT_W-1:0]  cnt_add;

    // whole pipeline holds only when a frame total cannot be queued
    assign adv    = !(a_valid_reg && a_fe_reg && fifo_full);
    assign full   = !adv;
    assign accept = push && adv;

    // keep even column and even row inside the limits
    assign kept_now = (col_reg < COL_W'(MAX_WIDTH)) && (row_reg < ROW_W'(MAX_HEIGHT))
                      && !col_reg[0] && !row_reg[0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (line_end)
            begin
                col_next = '0;
                if (row_reg < ROW_W'(MAX_HEIGHT))
                    row_next = row_reg + ROW_W'(1);
            end
            else if (col_reg < COL_W'(MAX_WIDTH))
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 0 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_kept_reg <= kept_now;
            s0_bgr_reg  <= pixel_bgr;
            s0_hx_reg   <= HALF_W'(col_reg >> 1);
            s0_hy_reg   <= HALF_W'(row_reg >> 1);
            s0_fe_reg   <= frame_end;
        end
    end

    // max, min and hue sector
    assign b = s0_bgr_reg[7:0];
    assign g = s0_bgr_reg[15:8];
    assign r = s0_bgr_reg[23:16];

    always_comb
    begin
        v  = r;
        mn = r;
        if (g > v)
            v = g;
        if (b > v)
            v = b;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
    end

    assign diff  = v - mn;
    assign r_max = (v == r);
    assign g_max = (v == g);

    // hue numerator offset so the quotient is never negative
    always_comb
    begin
        if (r_max)
        begin
            dpd    = {1'b0, g} + {1'b0, diff} - {1'b0, b};
            h_base = HUE_BASE_R;
        end
        else if (g_max)
        begin
            dpd    = {1'b0, b} + {1'b0, diff} - {1'b0, r};
            h_base = HUE_BASE_G;
        end
        else
        begin
            dpd    = {1'b0, r} + {1'b0, diff} - {1'b0, g};
            h_base = HUE_BASE_B;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.kept   <= s0_kept_reg;
            s1_side_reg.v_zero <= (v == 8'd0);
            s1_side_reg.d_zero <= (diff == 8'd0);
            s1_side_reg.v      <= v;
            s1_side_reg.h_base <= h_base;
            s1_side_reg.hx     <= s0_hx_reg;
            s1_side_reg.hy     <= s0_hy_reg;
            s1_side_reg.fe     <= s0_fe_reg;
            s1_snum_reg <= PIX_NUM_W'(diff) * PIX_NUM_W'(SAT_SCALE) + PIX_NUM_W'(v);
            s1_sden_reg <= {v, 1'b0};
            s1_hnum_reg <= PIX_NUM_W'(dpd) * PIX_NUM_W'(HUE_SCALE) + PIX_NUM_W'(diff);
            s1_hden_reg <= {diff, 1'b0};
        end
    end

    // saturation and hue quotients
    hcm_pix_div u_sat_div
    (
        .clk  (clk),
        .en   (adv),
        .num  (s1_snum_reg),
        .den  (s1_sden_reg),
        .quot (sq)
    );

    hcm_pix_div u_hue_div
    (
        .clk  (clk),
        .en   (adv),
        .num  (s1_hnum_reg),
        .den  (s1_hden_reg),
        .quot (hq)
    );

    // sideband follows the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= (pv_reg << 1) | PIX_Q_W'(s1_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s1_side_reg;
            for (int i = 1; i < PIX_Q_W; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_out = side_reg[PIX_Q_W-1];

    // hue wrap into 0..179 and inclusive range test
    assign h9 = 9'(side_out.h_base) + 9'(hq);

    always_comb
    begin
        if (side_out.d_zero)
            h = 8'd0;
        else if (h9 < 9'(HUE_SHIFT))
            h = 8'(h9 + 9'(HUE_WRAP - HUE_SHIFT));
        else
            h = 8'(h9 - 9'(HUE_SHIFT));
    end

    assign s   = side_out.v_zero ? 8'd0 : sq;
    assign hit = side_out.kept
                 && (h >= bounds.hue_low) && (h <= bounds.hue_high)
                 && (s >= bounds.sat_low) && (s <= bounds.sat_high)
                 && (side_out.v >= bounds.val_low) && (side_out.v <= bounds.val_high);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= pv_reg[PIX_Q_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_hit_reg <= hit;
            a_hx_reg  <= side_out.hx;
            a_hy_reg  <= side_out.hy;
            a_fe_reg  <= side_out.fe;
        end
    end

    // running sums, handed to the queue at frame end
    assign sum_x_add = sum_x_reg + (a_hit_reg ? SUM_W'(a_hx_reg) : SUM_W'(0));
    assign sum_y_add = sum_y_reg + (a_hit_reg ? SUM_W'(a_hy_reg) : SUM_W'(0));
    assign cnt_add   = cnt_reg + CNT_W'(a_hit_reg);

    assign fifo_push       = adv && a_valid_reg && a_fe_reg;
    assign fifo_data.sum_x = sum_x_add;
    assign fifo_data.sum_y = sum_y_add;
    assign fifo_data.count = cnt_add;

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        cnt_next   = cnt_reg;
        if (adv && a_valid_reg)
        begin
            if (a_fe_reg)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
                cnt_next   = '0;
            end
            else
            begin
                sum_x_next = sum_x_add;
                sum_y_next = sum_y_add;
                cnt_next   = cnt_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### sv/hcm_frame_fifo.sv
module hcm_frame_fifo
    import hcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  frame_sum_t din,
    input  logic       pop,
    output logic       empty,
    output frame_sum_t dout
);

    frame_sum_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign full    = (fill_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointer wrap and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + FIFO_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + FIFO_PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

### sv/hcm_centroid_div.sv
module hcm_centroid_div
    import hcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    output logic                fifo_pop,
    input  frame_sum_t          fifo_data,
    output logic                empty,
    input  logic                pop,
    output logic                found,
    output logic [CENTER_W-1:0] center_x,
    output logic [CENTER_W-1:0] center_y,
    output logic [MCOUNT_W-1:0] match_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    remx_reg, remy_reg, dsh_reg;
    logic [HALF_W-1:0]   qx_reg, qy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg;
    logic [CENTER_W-1:0] cx_reg, cy_reg;
    logic [MCOUNT_W-1:0] mc_reg;
    logic                gex, gey, load_out;

    assign gex      = (remx_reg >= dsh_reg);
    assign gey      = (remy_reg >= dsh_reg);
    assign fifo_pop = (state_reg == ST_IDLE) && !fifo_empty;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || pop);

    // frame sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register in front of the output side
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // restoring division of both sums by the count, one bit per cycle
    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            remx_reg <= fifo_data.sum_x;
            remy_reg <= fifo_data.sum_y;
            dsh_reg  <= SUM_W'(fifo_data.count) << (HALF_W - 1);
            cnt_reg  <= fifo_data.count;
            qx_reg   <= '0;
            qy_reg   <= '0;
            step_reg <= STEP_W'(HALF_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            remx_reg <= gex ? (remx_reg - dsh_reg) : remx_reg;
            remy_reg <= gey ? (remy_reg - dsh_reg) : remy_reg;
            qx_reg   <= (qx_reg << 1) | HALF_W'(gex);
            qy_reg   <= (qy_reg << 1) | HALF_W'(gey);
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg <= (cnt_reg != '0);
            cx_reg    <= (cnt_reg != '0) ? CENTER_W'({qx_reg, 1'b0}) : '0;
            cy_reg    <= (cnt_reg != '0) ? CENTER_W'({qy_reg, 1'b0}) : '0;
            mc_reg    <= MCOUNT_W'(cnt_reg);
        end
    end

    assign empty       = !out_valid_reg;
    assign found       = found_reg;
    assign center_x    = cx_reg;
    assign center_y    = cy_reg;
    assign match_count = mc_reg;

endmodule

### sv/hsv_color_mask_centroid_unit.sv
// channel   direction  handshake            payload
// pixels    in         push / full          pixel_bgr, line_end, frame_end
// results   out        pop / empty          found, center_x, center_y, match_count
// config    in         apb psel/penable     paddr, pwdata, prdata (bounds at 4*i)
//
// one pixel is taken every clock while full is low; a pixel reaches the sums through
// the hsv pipeline: capture and operand registers, the 8-stage saturation and hue
// dividers and the accumulate register; the back divider gives one quotient bit per cycle.
// reset clears counters, sums, queue and result valid; bounds return to defaults.
// full rises only when a frame total cannot enter the two-entry queue; it then stalls
// the whole pixel pipeline until the result side drains.
module hsv_color_mask_centroid_unit
    import hcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [23:0]         pixel_bgr,
    input  logic                line_end,
    input  logic                frame_end,
    output logic                empty,
    input  logic                pop,
    output logic                found,
    output logic [CENTER_W-1:0] center_x,
    output logic [CENTER_W-1:0] center_y,
    output logic [MCOUNT_W-1:0] match_count,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    hsv_bounds_t bounds_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic [7:0]  rd_val;
    logic        fifo_push, fifo_full, fifo_pop, fifo_empty;
    frame_sum_t  fifo_din, fifo_dout;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.hue_low  <= RST_HUE_LOW;
            bounds_reg.hue_high <= RST_HUE_HIGH;
            bounds_reg.sat_low  <= RST_SAT_LOW;
            bounds_reg.sat_high <= RST_SAT_HIGH;
            bounds_reg.val_low  <= RST_VAL_LOW;
            bounds_reg.val_high <= RST_VAL_HIGH;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_HUE_LOW:  bounds_reg.hue_low  <= pwdata[7:0];
                REG_HUE_HIGH: bounds_reg.hue_high <= pwdata[7:0];
                REG_SAT_LOW:  bounds_reg.sat_low  <= pwdata[7:0];
                REG_SAT_HIGH: bounds_reg.sat_high <= pwdata[7:0];
                REG_VAL_LOW:  bounds_reg.val_low  <= pwdata[7:0];
                REG_VAL_HIGH: bounds_reg.val_high <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_HUE_LOW:  rd_val = bounds_reg.hue_low;
            REG_HUE_HIGH: rd_val = bounds_reg.hue_high;
            REG_SAT_LOW:  rd_val = bounds_reg.sat_low;
            REG_SAT_HIGH: rd_val = bounds_reg.sat_high;
            REG_VAL_LOW:  rd_val = bounds_reg.val_low;
            REG_VAL_HIGH: rd_val = bounds_reg.val_high;
            default:      rd_val = 8'd0;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);

    // pixel classification and accumulation
    hcm_hsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_bgr (pixel_bgr),
        .line_end  (line_end),
        .frame_end (frame_end),
        .bounds    (bounds_reg),
        .fifo_push (fifo_push),
        .fifo_full (fifo_full),
        .fifo_data (fifo_din)
    );

    // frame totals queue
    hcm_frame_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .full  (fifo_full),
        .din   (fifo_din),
        .pop   (fifo_pop),
        .empty (fifo_empty),
        .dout  (fifo_dout)
    );

    // centroid division and result transaction
    hcm_centroid_div u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .fifo_pop    (fifo_pop),
        .fifo_data   (fifo_dout),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .center_x    (center_x),
        .center_y    (center_y),
        .match_count (match_count)
    );

endmodule
